// ===== design/hdlf_pkg.sv =====
`timescale 1ns / 1ps

package hdlf_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TILDE = 8'h7e;

  localparam logic [2:0] CK_HEX_HI  = 3'd0;
  localparam logic [2:0] CK_HEX_LO  = 3'd1;
  localparam logic [2:0] CK_SPACE   = 3'd2;
  localparam logic [2:0] CK_ASCII   = 3'd3;
  localparam logic [2:0] CK_NEWLINE = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
  } char_req_t;

endpackage

// ===== design/hdlf_in_if.sv =====
`timescale 1ns / 1ps

interface hdlf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// ===== design/hdlf_out_if.sv =====
`timescale 1ns / 1ps

interface hdlf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink (input valid, input out_char, input run_last, output ready);
endinterface

// ===== design/hex_dump_line_formatter_top.sv =====
`timescale 1ns / 1ps
// channel   dir  payload                         handshake
// data_in   in   data_byte[7:0], final_byte      valid/ready
// data_out  out  out_char[7:0], run_last        valid/ready
//
// one byte in at a time; it yields one character per cycle while data_out takes
// them: two hex digits per byte, plus a space at an odd position; when the line
// closes, two spaces per padded even position and three per padded odd one, one
// ascii character per stored byte and the newline, then it returns to the accept
// state. the ascii column is read from the line store (synchronous read). rst is
// synchronous and clears the sequencer, line position and output valid. a stalled
// data_out holds its word and the sequencer waits.

module hex_dump_line_formatter_top
  import hdlf_pkg::*;
#(
  parameter int LINE_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst,
  hdlf_in_if.sink           data_in,
  hdlf_out_if.source        data_out
);

  localparam int PW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(LINE_BYTES - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HI   = 3'd1;
  localparam logic [2:0] ST_LO   = 3'd2;
  localparam logic [2:0] ST_SP   = 3'd3;
  localparam logic [2:0] ST_PAD  = 3'd4;
  localparam logic [2:0] ST_ASC  = 3'd5;
  localparam logic [2:0] ST_NL   = 3'd6;

  logic [7:0]    line_store [LINE_BYTES];
  logic [7:0]    rdata;

  logic [2:0]    state, state_next;
  logic [PW-1:0] pos;
  logic [PW-1:0] cur;
  logic [PW-1:0] cnt, cnt_next;
  logic [1:0]    psub, psub_next;
  logic [7:0]    cur_byte;
  logic          close;
  logic          out_valid;
  logic [7:0]    out_char;
  logic          out_last;

  logic          accept;
  logic          emit;
  logic          emit_last;
  logic          pad_needed;
  char_req_t     req;
  logic [7:0]    ch;

  assign accept     = data_in.valid && data_in.ready;
  assign data_in.ready = (state == ST_IDLE);
  assign emit       = (state != ST_IDLE) && (!out_valid || data_out.ready);
  assign pad_needed = (cur != LAST_POS);

  assign data_out.valid    = out_valid;
  assign data_out.out_char = out_char;
  assign data_out.run_last = out_last;

  hdlf_char_sel u_char_sel (
    .req (req),
    .ch  (ch)
  );

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    psub_next  = psub;
    emit_last  = 1'b0;
    req.kind   = CK_SPACE;
    req.value  = cur_byte;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_HI;
      end
      ST_HI: begin
        req.kind = CK_HEX_HI;
        if (emit) state_next = ST_LO;
      end
      ST_LO: begin
        req.kind  = CK_HEX_LO;
        emit_last = !cur[0] && !close;
        if (emit) begin
          if (cur[0]) begin
            state_next = ST_SP;
          end else if (!close) begin
            state_next = ST_IDLE;
          end else if (pad_needed) begin
            state_next = ST_PAD;
            cnt_next   = cur + 1'b1;
            psub_next  = 2'd0;
          end else begin
            state_next = ST_ASC;
            cnt_next   = '0;
          end
        end
      end
      ST_SP: begin
        req.kind  = CK_SPACE;
        emit_last = !close;
        if (emit) begin
          if (!close) begin
            state_next = ST_IDLE;
          end else if (pad_needed) begin
            state_next = ST_PAD;
            cnt_next   = cur + 1'b1;
            psub_next  = 2'd0;
          end else begin
            state_next = ST_ASC;
            cnt_next   = '0;
          end
        end
      end
      ST_PAD: begin
        req.kind = CK_SPACE;
        if (emit) begin
          if (psub == 2'd0 || (psub == 2'd1 && cnt[0])) begin
            psub_next = psub + 2'd1;
          end else if (cnt == LAST_POS) begin
            state_next = ST_ASC;
            cnt_next   = '0;
          end else begin
            cnt_next  = cnt + 1'b1;
            psub_next = 2'd0;
          end
        end
      end
      ST_ASC: begin
        req.kind  = CK_ASCII;
        req.value = rdata;
        if (emit) begin
          if (cnt == cur) begin
            state_next = ST_NL;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      ST_NL: begin
        req.kind  = CK_NEWLINE;
        emit_last = 1'b1;
        if (emit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // read address follows cnt_next, so rdata always matches cnt; the only write
  // happens at accept, before any ascii read of that line
  always_ff @(posedge clk) begin
    if (accept) begin
      line_store[pos] <= data_in.data_byte;
    end
    rdata <= line_store[cnt_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (data_in.final_byte || pos == LAST_POS) begin
          pos <= '0;
        end else begin
          pos <= pos + 1'b1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (data_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt  <= cnt_next;
    psub <= psub_next;
    if (accept) begin
      cur      <= pos;
      cur_byte <= data_in.data_byte;
      close    <= data_in.final_byte || (pos == LAST_POS);
    end
    if (emit) begin
      out_char <= ch;
      out_last <= emit_last;
    end
  end

  a_one_word_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !data_in.ready)
    else $error("input taken while a byte is still being formatted");

  a_newline_ends_run: assert property (@(posedge clk) disable iff (rst)
    (data_out.valid && data_out.out_char == CH_NL) |-> data_out.run_last)
    else $error("newline not marked as last character of its byte");

  a_ascii_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ASC) |-> (cnt <= cur))
    else $error("ascii column reads past the current line");

  a_close_resets_pos: assert property (@(posedge clk) disable iff (rst)
    (accept && (data_in.final_byte || pos == LAST_POS)) |=> (pos == '0))
    else $error("line position not cleared after closing byte");

endmodule

// ===== design/hdlf_char_sel.sv =====
`timescale 1ns / 1ps

module hdlf_char_sel
  import hdlf_pkg::*;
(
  input  char_req_t  req,
  output logic [7:0] ch
);

  logic [3:0] nib;

  always_comb begin
    nib = (req.kind == CK_HEX_HI) ? req.value[7:4] : req.value[3:0];
    case (req.kind)
      CK_HEX_HI, CK_HEX_LO: begin
        if (nib < 4'd10) begin
          ch = CH_ZERO + {4'd0, nib};
        end else begin
          ch = CH_A + {4'd0, nib} - 8'd10;
        end
      end
      CK_SPACE: ch = CH_SPACE;
      CK_ASCII: begin
        if (req.value < CH_SPACE || req.value > CH_TILDE) begin
          ch = CH_DOT;
        end else begin
          ch = req.value;
        end
      end
      CK_NEWLINE: ch = CH_NL;
      default: ch = CH_DOT;
    endcase
  end

endmodule

// ===== tb/sv/tb_hex_dump_line_formatter_top.sv =====
`timescale 1ns / 1ps

module tb_hex_dump_line_formatter_top;
  import hdlf_pkg::*;

  localparam int LINE_BYTES = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 60;
  localparam int RANDOM_BYTES = 300;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } dump_char_t;

  class dump_scoreboard;
    logic [7:0] line_bytes[16];
    logic [3:0] line_pos;
    dump_char_t expected_chars[$];
    int errors;

    function new();
      line_pos = 4'd0;
      errors = 0;
      for (int i = 0; i < 16; i++) line_bytes[i] = 8'h00;
    endfunction

    function logic [7:0] hex_char(logic [3:0] v);
      if (v < 4'd10) return CH_ZERO + {4'd0, v};
      return CH_A + {4'd0, v} - 8'd10;
    endfunction

    function logic [7:0] ascii_char(logic [7:0] c);
      if (c < CH_SPACE || c > CH_TILDE) return CH_DOT;
      return c;
    endfunction

    // work out the text caused by one accepted byte
    function void note_byte(logic [7:0] b, logic fin);
      logic [7:0] text[48];
      int n;
      int used;
      n = 0;
      line_bytes[line_pos] = b;
      text[n++] = hex_char(b[7:4]);
      text[n++] = hex_char(b[3:0]);
      if (line_pos[0]) text[n++] = CH_SPACE;
      used = int'(line_pos) + 1;
      if (used >= LINE_BYTES || fin) begin
        // pad missing positions of a short line
        for (int p = used; p < LINE_BYTES; p++) begin
          text[n++] = CH_SPACE;
          text[n++] = CH_SPACE;
          if (p % 2 == 1) text[n++] = CH_SPACE;
        end
        for (int p = 0; p < used; p++) text[n++] = ascii_char(line_bytes[p]);
        text[n++] = CH_NL;
        line_pos = 4'd0;
      end else begin
        line_pos = used[3:0];
      end
      for (int i = 0; i < n; i++) expected_chars.push_back({text[i], i == n - 1});
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      dump_char_t exp_c;
      if (expected_chars.size() == 0) begin
        $error("unexpected word: out_char %h run_last %b", ch, last);
        errors++;
        return;
      end
      exp_c = expected_chars.pop_front();
      if (ch !== exp_c.ch) begin
        $error("out_char expected %h actual %h", exp_c.ch, ch);
        errors++;
      end
      if (last !== exp_c.last) begin
        $error("run_last expected %b actual %b", exp_c.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic no_idle;
  int idle_cycles;
  dump_scoreboard sb;

  hdlf_in_if in_ch();
  hdlf_out_if out_ch();

  hex_dump_line_formatter_top #(
    .LINE_BYTES(LINE_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .data_in(in_ch),
    .data_out(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 29);
  end

  // input noted before output is checked on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.data_byte, in_ch.final_byte);
      if (out_ch.valid && out_ch.ready) sb.check_char(out_ch.out_char, out_ch.run_last);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!no_idle && $urandom_range(0, 99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.final_byte <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // hold the sender until the whole dump text so far has come out
  task automatic drain_text();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(0, 31));
      1: return 8'($urandom_range(32, 126));
      2: return 8'($urandom_range(127, 255));
      3: begin
        case ($urandom_range(0, 5))
          0: return 8'h1f;
          1: return 8'h20;
          2: return 8'h7e;
          3: return 8'h7f;
          4: return 8'h00;
          default: return 8'hff;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [7:0] full_line[16];
    sb = new();
    rst = 1'b1;
    no_idle = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.final_byte = 1'b0;
    full_line = '{8'h1f, 8'h20, 8'h7e, 8'h7f, 8'hff, 8'h09, 8'h0a, 8'h41,
                  8'h61, 8'h39, 8'h80, 8'h5a, 8'h30, 8'ha0, 8'hde, 8'had};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single byte region, the longest run of text
    send_byte(8'h00, 1'b1);
    // full line closed by the final byte, no padding
    for (int i = 0; i < 16; i++) send_byte(full_line[i], i == 15);
    // short final lines ending at odd and at even position
    send_byte(8'h9a, 1'b0);
    send_byte(8'ha9, 1'b1);
    send_byte(8'h7e, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h1f, 1'b1);
    drain_text();

    for (int i = 0; i < RANDOM_BYTES; i++) begin
      no_idle = (i >= 120 && i < 200);
      if (i % 75 == 37) drain_text();
      send_byte(pick_byte(), $urandom_range(0, 11) == 0);
    end
    // close any open line
    send_byte(pick_byte(), 1'b1);
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
